// File: rtl/core/serial_packet_slave_responder_macros.svh
// Assertion macros for the serial packet slave responder.
// Included by the files that carry concurrent assertions; no other dependency.
`ifndef SERIAL_PACKET_SLAVE_RESPONDER_MACROS_SVH
`define SERIAL_PACKET_SLAVE_RESPONDER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SPSR_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define SPSR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/spsr_pkg.sv
// Shared types and constants of the serial packet slave responder.
// No dependencies; used by every RTL module and by the testbench.
package spsr_pkg;

	// Configuration register indexes
	typedef enum logic [1:0] {
		REG_OWN_ADDRESS   = 2'd0,
		REG_SERIAL_NUMBER = 2'd1,
		REG_TIMEOUT_TICKS = 2'd2,
		REG_UNUSED        = 2'd3
	} spsr_reg_t;

	// Configuration reset values
	localparam logic [7:0]  OWN_ADDRESS_RST   = 8'h02;
	localparam logic [31:0] SERIAL_NUMBER_RST = 32'h1122_3344;
	localparam logic [7:0]  TIMEOUT_TICKS_RST = 8'd15;

	// Command codes (second payload byte, first must be zero)
	localparam logic [7:0] CMD_PREFIX = 8'h00;
	localparam logic [7:0] CMD_PING   = 8'h00;
	localparam logic [7:0] CMD_STATUS = 8'h01;
	localparam logic [7:0] CMD_INPUT  = 8'h02;

	// Length codes placed in the reply header
	localparam logic [7:0] LEN_PING   = 8'h05;
	localparam logic [7:0] LEN_STATUS = 8'h03;
	localparam logic [7:0] LEN_INPUT  = 8'h02;

	localparam logic [7:0] IDLE_MAX = 8'hFF;

	typedef enum logic [1:0] {
		KIND_PING   = 2'd0,
		KIND_STATUS = 2'd1,
		KIND_INPUT  = 2'd2
	} spsr_kind_t;

	// Channel payloads
	typedef struct packed {
		logic       func;
		logic [7:0] rx_byte;
		logic       pin_level;
	} spsr_in_t;

	typedef struct packed {
		logic [7:0] tx_byte;
		logic       last_byte;
	} spsr_out_t;

	typedef struct packed {
		logic [1:0]  index;
		logic [31:0] data;
	} spsr_cfg_t;

	// Reply descriptor handed from the parser to the serializer
	typedef struct packed {
		logic [7:0]  sender;
		logic [7:0]  own;
		spsr_kind_t  kind;
		logic [31:0] data;
	} spsr_reply_t;

	// Parser settings taken from the configuration registers
	typedef struct packed {
		logic [7:0]  own_address;
		logic [31:0] serial_number;
		logic [7:0]  timeout_ticks;
	} spsr_settings_t;

endpackage

// File: rtl/core/spsr_chan_if.sv
// Valid/ready channel carrying one payload type per beat.
// Payload types come from spsr_pkg.
interface spsr_chan_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// File: rtl/core/spsr_front.sv
// Packet parser: takes received bytes and ticks, tracks framing, checksum,
// counters and timeouts, and pushes a reply descriptor. Depends on spsr_pkg.
module spsr_front
	import spsr_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	spsr_chan_if.sink      req,
	input  spsr_settings_t settings,
	output logic           push_valid,
	output spsr_reply_t    push_data,
	input  logic           push_ready
);

	typedef enum logic [1:0] {
		PH_ADDR   = 2'd0,
		PH_SENDER = 2'd1,
		PH_LEN    = 2'd2,
		PH_DATA   = 2'd3
	} phase_t;

	phase_t     phase_q;
	logic       ignore_q;
	logic [7:0] sender_q;
	logic [7:0] len_q;
	logic [7:0] count_q;
	logic [7:0] xor_q;
	logic [7:0] cmd0_q;
	logic [7:0] cmd1_q;
	logic [7:0] cec_q;
	logic [7:0] tmo_q;
	logic [7:0] idle_q;

	logic       accept;
	logic [7:0] rx_b;
	logic [7:0] xor_n;
	logic [7:0] count_n;
	logic [7:0] cmd0_n;
	logic [7:0] cmd1_n;
	logic [7:0] idle_inc;
	logic       data_end;
	logic       sum_ok;
	logic       reply_ok;
	spsr_kind_t kind;

	// Stall only when the reply queue has no room
	assign req.ready = push_ready;
	assign accept    = req.valid && req.ready;
	assign rx_b      = req.payload.rx_byte;

	// Payload byte bookkeeping
	always_comb begin
		xor_n    = xor_q ^ rx_b;
		count_n  = count_q + 8'd1;
		cmd0_n   = (count_q == 8'd0) ? rx_b : cmd0_q;
		cmd1_n   = (count_q == 8'd1) ? rx_b : cmd1_q;
		idle_inc = (idle_q == IDLE_MAX) ? idle_q : idle_q + 8'd1;
		data_end = (phase_q == PH_DATA) && !req.payload.func && (count_n >= len_q);
		sum_ok   = (xor_n == 8'h00);
	end

	// Decode the command of a finishing packet
	always_comb begin
		kind     = KIND_PING;
		reply_ok = 1'b0;
		if (!ignore_q && sum_ok && (len_q >= 8'd2) && (cmd0_n == CMD_PREFIX)) begin
			case (cmd1_n)
				CMD_PING: begin
					kind     = KIND_PING;
					reply_ok = 1'b1;
				end
				CMD_STATUS: begin
					kind     = KIND_STATUS;
					reply_ok = 1'b1;
				end
				CMD_INPUT: begin
					kind     = KIND_INPUT;
					reply_ok = 1'b1;
				end
				default: begin
					reply_ok = 1'b0;
				end
			endcase
		end
	end

	// Build the descriptor for the queue
	always_comb begin
		push_valid       = accept && data_end && reply_ok;
		push_data.sender = sender_q;
		push_data.own    = settings.own_address;
		push_data.kind   = kind;
		case (kind)
			KIND_PING:   push_data.data = settings.serial_number;
			KIND_STATUS: push_data.data = {cec_q, tmo_q, 16'h0000};
			KIND_INPUT:  push_data.data = {7'd0, req.payload.pin_level, 24'h000000};
			default:     push_data.data = 32'h0000_0000;
		endcase
	end

	// Advance the framing state on each accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_ADDR;
			ignore_q <= 1'b0;
			sender_q <= 8'h00;
			len_q    <= 8'h00;
			count_q  <= 8'h00;
			xor_q    <= 8'h00;
			cmd0_q   <= 8'h00;
			cmd1_q   <= 8'h00;
			cec_q    <= 8'h00;
			tmo_q    <= 8'h00;
			idle_q   <= 8'h00;
		end else if (accept) begin
			if (req.payload.func) begin
				// Tick: count idle time, drop the packet on timeout
				if (phase_q != PH_ADDR) begin
					if (idle_inc > settings.timeout_ticks) begin
						tmo_q    <= tmo_q + 8'd1;
						phase_q  <= PH_ADDR;
						ignore_q <= 1'b0;
						sender_q <= 8'h00;
						len_q    <= 8'h00;
						count_q  <= 8'h00;
						xor_q    <= 8'h00;
						cmd0_q   <= 8'h00;
						cmd1_q   <= 8'h00;
						idle_q   <= 8'h00;
					end else begin
						idle_q <= idle_inc;
					end
				end
			end else begin
				idle_q <= 8'h00;
				case (phase_q)
					PH_ADDR: begin
						ignore_q <= (rx_b != settings.own_address);
						xor_q    <= rx_b;
						phase_q  <= PH_SENDER;
					end
					PH_SENDER: begin
						sender_q <= rx_b;
						xor_q    <= xor_n;
						phase_q  <= PH_LEN;
					end
					PH_LEN: begin
						if (rx_b == 8'h00) begin
							phase_q  <= PH_ADDR;
							ignore_q <= 1'b0;
							sender_q <= 8'h00;
							len_q    <= 8'h00;
							count_q  <= 8'h00;
							xor_q    <= 8'h00;
							cmd0_q   <= 8'h00;
							cmd1_q   <= 8'h00;
						end else begin
							len_q   <= rx_b;
							xor_q   <= xor_n;
							count_q <= 8'h00;
							phase_q <= PH_DATA;
						end
					end
					default: begin
						if (data_end) begin
							if (!ignore_q && !sum_ok) begin
								cec_q <= cec_q + 8'd1;
							end
							phase_q  <= PH_ADDR;
							ignore_q <= 1'b0;
							sender_q <= 8'h00;
							len_q    <= 8'h00;
							count_q  <= 8'h00;
							xor_q    <= 8'h00;
							cmd0_q   <= 8'h00;
							cmd1_q   <= 8'h00;
						end else begin
							xor_q   <= xor_n;
							count_q <= count_n;
							cmd0_q  <= cmd0_n;
							cmd1_q  <= cmd1_n;
						end
					end
				endcase
			end
		end
	end

endmodule

// File: rtl/core/spsr_queue.sv
// Small register queue of reply descriptors between parser and serializer.
// Depends on spsr_pkg for the descriptor type.
module spsr_queue
	import spsr_pkg::*;
#(
	parameter int DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push_valid,
	input  spsr_reply_t push_data,
	output logic        push_ready,
	output logic        pop_valid,
	output spsr_reply_t pop_data,
	input  logic        pop_ready
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	spsr_reply_t      slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] level_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (level_q != CNT_FULL);
	assign pop_valid  = (level_q != '0);
	assign pop_data   = slot_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// Store the descriptor
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	// Advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				level_q <= level_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				level_q <= level_q - CNT_W'(1);
			end
		end
	end

endmodule

// File: rtl/core/spsr_back.sv
// Reply serializer: walks one descriptor a byte per beat into an output
// register and closes with the XOR byte. Depends on spsr_pkg.
module spsr_back
	import spsr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        pop_valid,
	input  spsr_reply_t pop_data,
	output logic        pop_ready,
	spsr_chan_if.source rsp
);

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_SEND = 1'b1
	} state_t;

	state_t      state_q;
	spsr_reply_t rep_q;
	logic [2:0]  idx_q;
	logic [7:0]  xacc_q;
	logic        out_valid_q;
	logic [7:0]  out_byte_q;
	logic        out_last_q;

	logic [7:0]  cur_byte;
	logic [7:0]  code;
	logic [2:0]  last_idx;
	logic        load;
	logic        at_end;
	logic        take;

	assign rsp.valid             = out_valid_q;
	assign rsp.payload.tx_byte   = out_byte_q;
	assign rsp.payload.last_byte = out_last_q;

	// Reply header code and final index for each reply kind
	always_comb begin
		case (rep_q.kind)
			KIND_PING: begin
				code     = LEN_PING;
				last_idx = 3'd7;
			end
			KIND_STATUS: begin
				code     = LEN_STATUS;
				last_idx = 3'd5;
			end
			KIND_INPUT: begin
				code     = LEN_INPUT;
				last_idx = 3'd4;
			end
			default: begin
				code     = 8'h00;
				last_idx = 3'd4;
			end
		endcase
	end

	// Select the byte at the current position
	always_comb begin
		case (idx_q)
			3'd0:    cur_byte = rep_q.sender;
			3'd1:    cur_byte = rep_q.own;
			3'd2:    cur_byte = code;
			3'd3:    cur_byte = rep_q.data[31:24];
			3'd4:    cur_byte = rep_q.data[23:16];
			3'd5:    cur_byte = rep_q.data[15:8];
			3'd6:    cur_byte = rep_q.data[7:0];
			default: cur_byte = 8'h00;
		endcase
	end

	assign load      = (state_q == ST_SEND) && (!out_valid_q || rsp.ready);
	assign at_end    = (idx_q == last_idx);
	assign pop_ready = (state_q == ST_IDLE) || (load && at_end);
	assign take      = pop_valid && pop_ready;

	// Hold state and the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rep_q       <= '0;
			idx_q       <= 3'd0;
			xacc_q      <= 8'h00;
			out_valid_q <= 1'b0;
			out_byte_q  <= 8'h00;
			out_last_q  <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				out_byte_q  <= at_end ? xacc_q : cur_byte;
				out_last_q  <= at_end;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end

			if (take) begin
				rep_q   <= pop_data;
				state_q <= ST_SEND;
				idx_q   <= 3'd0;
				xacc_q  <= 8'h00;
			end else if (load) begin
				if (at_end) begin
					state_q <= ST_IDLE;
				end else begin
					idx_q  <= idx_q + 3'd1;
					xacc_q <= xacc_q ^ cur_byte;
				end
			end
		end
	end

endmodule

// File: rtl/core/serial_packet_slave_responder.sv
// Top level of the serial packet slave responder: configuration registers,
// parser, reply queue and serializer. Depends on spsr_pkg, spsr_chan_if and
// the submodules spsr_front, spsr_queue and spsr_back.

// The parser takes one beat (a received byte or a millisecond tick) per clock
// and decides a reply on the last payload byte of a packet, in the same cycle.
// A reply of 5, 6 or 8 bytes passes the reply queue and the serializer's
// descriptor and output registers, going out one byte per clock while the
// receiver is ready; the queue holds QUEUE_DEPTH pending replies, and the input
// stalls only while it is full. Configuration writes are always ready and apply
// next cycle. Reset: own_address 2, serial_number 0x11223344, timeout_ticks 15.
module serial_packet_slave_responder
	import spsr_pkg::*;
#(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	spsr_chan_if.sink   req,
	spsr_chan_if.source rsp,
	spsr_chan_if.sink   cfg
);

	spsr_settings_t settings_q;
	logic           push_valid;
	logic           push_ready;
	spsr_reply_t    push_data;
	logic           pop_valid;
	logic           pop_ready;
	spsr_reply_t    pop_data;

	// Configuration writes
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settings_q.own_address   <= OWN_ADDRESS_RST;
			settings_q.serial_number <= SERIAL_NUMBER_RST;
			settings_q.timeout_ticks <= TIMEOUT_TICKS_RST;
		end else if (cfg.valid && cfg.ready) begin
			case (spsr_reg_t'(cfg.payload.index))
				REG_OWN_ADDRESS:   settings_q.own_address   <= cfg.payload.data[7:0];
				REG_SERIAL_NUMBER: settings_q.serial_number <= cfg.payload.data;
				REG_TIMEOUT_TICKS: settings_q.timeout_ticks <= cfg.payload.data[7:0];
				default: begin
					settings_q <= settings_q;
				end
			endcase
		end
	end

	spsr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.settings   (settings_q),
		.push_valid (push_valid),
		.push_data  (push_data),
		.push_ready (push_ready)
	);

	spsr_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_data  (push_data),
		.push_ready (push_ready),
		.pop_valid  (pop_valid),
		.pop_data   (pop_data),
		.pop_ready  (pop_ready)
	);

	spsr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_data  (pop_data),
		.pop_ready (pop_ready),
		.rsp       (rsp)
	);

`include "serial_packet_slave_responder_macros.svh"

	// A full queue must hold off the input side
	`SPSR_ASSERT_NOW(a_full_stalls_input, clk, arst_n, !push_ready, !req.ready, "input accepted with reply queue full")
	// A descriptor is never offered into a full queue
	`SPSR_ASSERT_NOW(a_no_push_when_full, clk, arst_n, push_valid, push_ready, "reply pushed into full queue")
	// Hold the reply beat while the receiver stalls
	`SPSR_ASSERT_NEXT(a_hold_while_stalled, clk, arst_n, rsp.valid && !rsp.ready, rsp.valid && $stable(rsp.payload), "reply beat changed while stalled")

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench of serial_packet_slave_responder: packet framing, replies and counters.
// Depends on spsr_pkg, spsr_chan_if and the responder RTL; reads no files.
module testbench;
	import spsr_pkg::*;

	localparam int LIMIT_CYCLES = 200000;
	localparam int SETTLE_CYCLES = 12;

	typedef enum logic [1:0] {
		RX_DEST    = 2'd0,
		RX_SENDER  = 2'd1,
		RX_LENGTH  = 2'd2,
		RX_PAYLOAD = 2'd3
	} rx_phase_t;

	logic clk = 1'b0;
	logic arst_n;

	spsr_chan_if #(.payload_t(spsr_in_t))  req_ch ();
	spsr_chan_if #(.payload_t(spsr_out_t)) rsp_ch ();
	spsr_chan_if #(.payload_t(spsr_cfg_t)) cfg_ch ();

	serial_packet_slave_responder dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch),
		.cfg(cfg_ch)
	);

	// Responder state as the checker sees it
	logic [7:0]  my_addr;
	logic [31:0] my_serial;
	logic [7:0]  my_timeout;
	rx_phase_t   rx_phase;
	logic        rx_foreign;
	logic [7:0]  rx_sender;
	logic [7:0]  rx_length;
	logic [7:0]  rx_count;
	logic [7:0]  rx_xor;
	logic [7:0]  rx_cmd [2];
	logic [7:0]  checksum_errors;
	logic [7:0]  timeouts;
	logic [7:0]  idle_ticks;

	spsr_in_t  rx_beats [$];
	spsr_out_t expected_tx [$];
	spsr_out_t want_tx;
	int        queued_bytes = 0;
	int        fail_count = 0;
	int        cycle_count = 0;
	int        idle_pct = 0;
	int        stall_pct = 0;
	logic      req_fire = 1'b0;

	always #2 clk = ~clk;

	task automatic report_mismatch(string msg);
		fail_count++;
		if (fail_count <= 40)
			$display("mismatch: %s", msg);
	endtask

	function automatic void clear_packet();
		rx_phase = RX_DEST;
		rx_foreign = 1'b0;
		rx_sender = '0;
		rx_length = '0;
		rx_count = '0;
		rx_xor = '0;
		rx_cmd[0] = '0;
		rx_cmd[1] = '0;
		idle_ticks = '0;
	endfunction

	// Decide the reply of a completed packet and queue its bytes
	function automatic void finish_packet(logic pin);
		logic [7:0] msg [$];
		logic [7:0] sum;
		sum = '0;
		if (rx_foreign)
			return;
		if (rx_xor != 8'd0) begin
			checksum_errors = checksum_errors + 8'd1;
			return;
		end
		if (rx_length < 8'd2 || rx_cmd[0] != CMD_PREFIX)
			return;
		msg.push_back(rx_sender);
		msg.push_back(my_addr);
		case (rx_cmd[1])
			CMD_PING: begin
				msg.push_back(LEN_PING);
				msg.push_back(my_serial[31:24]);
				msg.push_back(my_serial[23:16]);
				msg.push_back(my_serial[15:8]);
				msg.push_back(my_serial[7:0]);
			end
			CMD_STATUS: begin
				msg.push_back(LEN_STATUS);
				msg.push_back(checksum_errors);
				msg.push_back(timeouts);
			end
			CMD_INPUT: begin
				msg.push_back(LEN_INPUT);
				msg.push_back({7'd0, pin});
			end
			default: return;
		endcase
		foreach (msg[i]) begin
			expected_tx.push_back('{tx_byte: msg[i], last_byte: 1'b0});
			sum ^= msg[i];
		end
		expected_tx.push_back('{tx_byte: sum, last_byte: 1'b1});
	endfunction

	// Advance the packet parser by one accepted beat
	function automatic void predict_beat(spsr_in_t beat);
		if (beat.func) begin
			if (rx_phase != RX_DEST) begin
				if (idle_ticks != IDLE_MAX)
					idle_ticks = idle_ticks + 8'd1;
				if (idle_ticks > my_timeout) begin
					timeouts = timeouts + 8'd1;
					clear_packet();
				end
			end
			return;
		end
		idle_ticks = '0;
		case (rx_phase)
			RX_DEST: begin
				rx_foreign = (beat.rx_byte != my_addr);
				rx_xor = beat.rx_byte;
				rx_phase = RX_SENDER;
			end
			RX_SENDER: begin
				rx_sender = beat.rx_byte;
				rx_xor ^= beat.rx_byte;
				rx_phase = RX_LENGTH;
			end
			RX_LENGTH: begin
				if (beat.rx_byte == 8'd0) begin
					clear_packet();
				end else begin
					rx_length = beat.rx_byte;
					rx_xor ^= beat.rx_byte;
					rx_count = '0;
					rx_phase = RX_PAYLOAD;
				end
			end
			default: begin
				rx_xor ^= beat.rx_byte;
				if (rx_count < 8'd2)
					rx_cmd[rx_count[0]] = beat.rx_byte;
				rx_count = rx_count + 8'd1;
				if (rx_count >= rx_length) begin
					finish_packet(beat.pin_level);
					clear_packet();
				end
			end
		endcase
	endfunction

	function automatic void queue_byte(logic [7:0] b);
		rx_beats.push_back('{func: 1'b0, rx_byte: b, pin_level: 1'($urandom)});
		queued_bytes++;
	endfunction

	function automatic void queue_ticks(int n);
		repeat (n)
			rx_beats.push_back('{func: 1'b1, rx_byte: 8'($urandom), pin_level: 1'($urandom)});
	endfunction

	// Build one packet; the last payload byte balances the XOR unless corrupted
	function automatic void queue_packet(logic [7:0] dst, logic [7:0] src, logic [7:0] len,
			logic [7:0] cmd0, logic [7:0] cmd1, bit corrupt, int max_gap);
		logic [7:0] frame [$];
		logic [7:0] sum;
		frame.push_back(dst);
		frame.push_back(src);
		frame.push_back(len);
		for (int i = 0; i < len; i++)
			frame.push_back(i == 0 ? cmd0 : (i == 1 ? cmd1 : 8'($urandom)));
		if (len != 8'd0) begin
			sum = '0;
			for (int i = 0; i < frame.size() - 1; i++)
				sum ^= frame[i];
			frame[frame.size() - 1] = corrupt ? (sum ^ 8'($urandom_range(1, 255))) : sum;
		end
		foreach (frame[i]) begin
			if (i != 0 && max_gap > 0)
				queue_ticks($urandom_range(max_gap));
			queue_byte(frame[i]);
		end
	endfunction

	// Mostly well-formed requests to this node, the rest broken or foreign traffic
	function automatic void queue_traffic(int n_bytes, logic [7:0] addr, logic [7:0] tmo);
		int target;
		int pick;
		int gap;
		logic [7:0] len;
		logic [7:0] src;
		target = queued_bytes + n_bytes;
		while (queued_bytes < target) begin
			pick = $urandom_range(99);
			gap = ($urandom_range(4) == 0) ? 3 : 0;
			src = 8'($urandom);
			if ($urandom_range(49) == 0)
				len = 8'd255;
			else if ($urandom_range(9) == 0)
				len = 8'($urandom_range(7, 40));
			else
				len = 8'($urandom_range(3, 6));
			if (pick < 60) begin
				queue_packet(addr, src, len, CMD_PREFIX, 8'($urandom_range(2)), 1'b0, gap);
			end else if (pick < 70) begin
				queue_packet(addr ^ 8'($urandom_range(1, 255)), src, len, CMD_PREFIX,
					8'($urandom_range(2)), 1'b0, gap);
			end else if (pick < 78) begin
				queue_packet(addr, src, len, CMD_PREFIX, 8'($urandom_range(2)), 1'b1, gap);
			end else if (pick < 84) begin
				if ($urandom_range(1))
					queue_packet(addr, src, len, 8'($urandom_range(1, 255)), 8'($urandom),
						1'b0, gap);
				else
					queue_packet(addr, src, len, CMD_PREFIX, 8'($urandom_range(3, 255)),
						1'b0, gap);
			end else if (pick < 90) begin
				queue_packet(addr, src, 8'($urandom_range(1)), CMD_PREFIX, CMD_PING,
					1'($urandom), 0);
			end else if (tmo != IDLE_MAX) begin
				// abandon a packet or scramble framing, then let the gap time out
				if (pick < 95) begin
					queue_byte(addr);
					if ($urandom_range(1))
						queue_byte(src);
				end else begin
					repeat ($urandom_range(1, 8)) begin
						if ($urandom_range(1))
							queue_byte(8'($urandom));
						else
							queue_ticks(1);
					end
				end
				queue_ticks(int'(tmo) + 1);
			end
		end
	endfunction

	task automatic write_reg(spsr_reg_t idx, logic [31:0] value);
		@(negedge clk);
		cfg_ch.payload <= '{index: idx, data: value};
		cfg_ch.valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	// Hold until every beat is taken and every reply byte has come back
	task automatic wait_idle();
		while (rx_beats.size() != 0 || req_ch.valid || expected_tx.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES)
			@(posedge clk);
	endtask

	// Driver: present beats and drive receiver back-pressure
	always @(negedge clk) begin
		rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
		if (arst_n && (!req_ch.valid || req_fire)) begin
			if (rx_beats.size() != 0 && $urandom_range(99) >= idle_pct) begin
				req_ch.payload <= rx_beats.pop_front();
				req_ch.valid <= 1'b1;
			end else begin
				req_ch.valid <= 1'b0;
			end
		end
	end

	// Monitor: track accepted beats, register writes and reply bytes
	always @(posedge clk) begin
		req_fire <= req_ch.valid && req_ch.ready;
		if (arst_n) begin
			if (cfg_ch.valid && cfg_ch.ready) begin
				case (cfg_ch.payload.index)
					REG_OWN_ADDRESS:   my_addr = cfg_ch.payload.data[7:0];
					REG_SERIAL_NUMBER: my_serial = cfg_ch.payload.data;
					REG_TIMEOUT_TICKS: my_timeout = cfg_ch.payload.data[7:0];
					default: ;
				endcase
			end
			if (req_ch.valid && req_ch.ready)
				predict_beat(req_ch.payload);
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (expected_tx.size() == 0) begin
					report_mismatch($sformatf("reply byte %h with nothing expected",
						rsp_ch.payload.tx_byte));
				end else begin
					want_tx = expected_tx.pop_front();
					if (rsp_ch.payload.tx_byte !== want_tx.tx_byte)
						report_mismatch($sformatf("tx_byte %h, expected %h",
							rsp_ch.payload.tx_byte, want_tx.tx_byte));
					if (rsp_ch.payload.last_byte !== want_tx.last_byte)
						report_mismatch($sformatf("last_byte %b, expected %b on byte %h",
							rsp_ch.payload.last_byte, want_tx.last_byte, want_tx.tx_byte));
				end
			end
		end
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == LIMIT_CYCLES) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		logic [7:0] addr_sel;
		logic [31:0] serial_sel;
		req_ch.valid = 1'b0;
		req_ch.payload = '0;
		rsp_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.payload = '0;
		my_addr = OWN_ADDRESS_RST;
		my_serial = SERIAL_NUMBER_RST;
		my_timeout = TIMEOUT_TICKS_RST;
		checksum_errors = '0;
		timeouts = '0;
		clear_packet();
		arst_n = 1'b0;
		repeat (2)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed cases with reset settings and no idling
		queue_ticks(2);
		queue_packet(OWN_ADDRESS_RST, 8'h10, 8'd3, CMD_PREFIX, CMD_PING, 1'b0, 0);
		queue_packet(OWN_ADDRESS_RST, 8'hFF, 8'd3, CMD_PREFIX, CMD_INPUT, 1'b0, 1);
		queue_packet(8'h55, 8'h01, 8'd3, CMD_PREFIX, CMD_PING, 1'b0, 0);
		queue_packet(OWN_ADDRESS_RST, 8'h01, 8'd3, CMD_PREFIX, CMD_PING, 1'b1, 0);
		queue_packet(OWN_ADDRESS_RST, 8'h01, 8'd0, CMD_PREFIX, CMD_PING, 1'b0, 0);
		queue_packet(OWN_ADDRESS_RST, 8'h01, 8'd1, CMD_PREFIX, CMD_PING, 1'b0, 0);
		queue_packet(OWN_ADDRESS_RST, 8'h01, 8'd4, 8'h80, CMD_PING, 1'b0, 0);
		queue_packet(OWN_ADDRESS_RST, 8'h01, 8'd3, CMD_PREFIX, 8'h03, 1'b0, 0);
		// gap at the limit survives, one tick more aborts
		queue_byte(OWN_ADDRESS_RST);
		queue_byte(8'h01);
		queue_ticks(int'(TIMEOUT_TICKS_RST));
		queue_byte(8'd3);
		queue_byte(CMD_PREFIX);
		queue_byte(CMD_INPUT);
		queue_byte(OWN_ADDRESS_RST ^ 8'h01 ^ 8'd3 ^ CMD_PREFIX ^ CMD_INPUT);
		queue_byte(OWN_ADDRESS_RST);
		queue_byte(8'h01);
		queue_ticks(int'(TIMEOUT_TICKS_RST) + 1);
		queue_packet(OWN_ADDRESS_RST, 8'h01, 8'd3, CMD_PREFIX, CMD_STATUS, 1'b0, 0);
		wait_idle();

		// Lowest settings, no idling
		write_reg(REG_OWN_ADDRESS, 32'h0000_0000);
		write_reg(REG_SERIAL_NUMBER, 32'h0000_0000);
		write_reg(REG_TIMEOUT_TICKS, 32'h0000_0000);
		write_reg(REG_UNUSED, 32'hFFFF_FFFF);
		queue_traffic(30, 8'h00, 8'h00);
		wait_idle();

		// Highest settings, sender idle; a long gap saturates without timing out
		idle_pct = 60;
		write_reg(REG_OWN_ADDRESS, 32'h0000_00FF);
		write_reg(REG_SERIAL_NUMBER, 32'hFFFF_FFFF);
		write_reg(REG_TIMEOUT_TICKS, 32'h0000_00FF);
		queue_byte(8'hFF);
		queue_byte(8'h21);
		queue_ticks(260);
		queue_byte(8'd3);
		queue_byte(CMD_PREFIX);
		queue_byte(CMD_PING);
		queue_byte(8'hFF ^ 8'h21 ^ 8'd3 ^ CMD_PREFIX ^ CMD_PING);
		queue_traffic(30, 8'hFF, 8'hFF);
		wait_idle();

		// Random settings, receiver stalling
		idle_pct = 0;
		stall_pct = 60;
		addr_sel = 8'($urandom);
		serial_sel = $urandom;
		write_reg(REG_OWN_ADDRESS, {24'd0, addr_sel});
		write_reg(REG_SERIAL_NUMBER, serial_sel);
		write_reg(REG_TIMEOUT_TICKS, 32'($urandom_range(1, 20)));
		queue_traffic(30, addr_sel, my_timeout);
		wait_idle();

		// Random address, reset timeout, both sides idling
		idle_pct = 24;
		stall_pct = 24;
		addr_sel = 8'($urandom);
		serial_sel = $urandom;
		write_reg(REG_OWN_ADDRESS, {24'd0, addr_sel});
		write_reg(REG_SERIAL_NUMBER, serial_sel);
		write_reg(REG_TIMEOUT_TICKS, {24'd0, TIMEOUT_TICKS_RST});
		queue_traffic(30, addr_sel, TIMEOUT_TICKS_RST);
		wait_idle();

		if (expected_tx.size() != 0)
			report_mismatch("reply bytes still outstanding at end of run");
		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
